[design/sacl_pkg.sv]
`default_nettype none

package sacl_pkg;

   // payload widths fixed by the transaction format
   localparam int REQ_ADDR_WIDTH  = 32;
   localparam int LINE_IDX_WIDTH  = 4;

   // configuration port
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CFG_LOG2_WIDTH  = 3;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CFG_IDX_SET_LOG2 = 1'b0;

   // reset value of the set count register
   localparam logic [CFG_LOG2_WIDTH-1:0] RESET_SET_LOG2 = 3'd1;

   // lookup sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_PLACE,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

[design/sacl_if.sv]
`default_nettype none

// lookup request channel
interface sacl_req_if import sacl_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [REQ_ADDR_WIDTH-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

// lookup response channel
interface sacl_rsp_if import sacl_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic [LINE_IDX_WIDTH-1:0] line_index;

   modport source (output valid, output hit, output line_index, input ready);
   modport sink   (input valid, input hit, input line_index, output ready);
endinterface

`default_nettype wire

[design/sacl_csr.sv]
`default_nettype none

module sacl_csr import sacl_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready,
   output logic      [CFG_LOG2_WIDTH-1:0] set_log2,
   output logic                           clear
);

   logic [CFG_LOG2_WIDTH-1:0]  set_log2_ff;
   logic [CSR_INDEX_WIDTH-1:0] reg_index;
   logic                       wr_set_log2;

   assign reg_index   = paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_set_log2 = psel && penable && pwrite && (reg_index == CFG_IDX_SET_LOG2);

   // set count register
   always_ff @(posedge clock) begin
      if (reset) begin
         set_log2_ff <= RESET_SET_LOG2;
      end else if (wr_set_log2) begin
         set_log2_ff <= pwdata[CFG_LOG2_WIDTH-1:0];
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (reg_index == CFG_IDX_SET_LOG2) begin
         prdata[CFG_LOG2_WIDTH-1:0] = set_log2_ff;
      end
   end

   assign pready   = 1'b1;
   assign set_log2 = set_log2_ff;
   assign clear    = wr_set_log2;

endmodule

`default_nettype wire

[design/sacl_seq.sv]
`default_nettype none

module sacl_seq import sacl_pkg::*; #(
   parameter int LINES      = 16,
   parameter int ADDR_WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [CFG_LOG2_WIDTH-1:0] set_log2,
   input  wire logic                      clear,
   sacl_req_if.sink                       req,
   sacl_rsp_if.source                     rsp
);

   localparam int IDX_W  = $clog2(LINES);
   localparam int CNT_W  = $clog2(LINES + 1);
   localparam int KEEP_W = (ADDR_WIDTH < REQ_ADDR_WIDTH) ? ADDR_WIDTH : REQ_ADDR_WIDTH;
   localparam logic [CFG_LOG2_WIDTH-1:0] MAX_LOG2 = CFG_LOG2_WIDTH'($clog2(LINES + 1) - 1);

   state_type state_ff, state_in;

   logic [KEEP_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0]  set_ff, set_in;
   logic [IDX_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]  ways_ff, ways_in;
   logic [CNT_W-1:0]  way_ff, way_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_line_ff, free_line_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  line_ff, line_in;

   // line store, per-line valid bits and per-set fifo pointers
   logic [KEEP_W-1:0] line_mem [LINES];
   logic [KEEP_W-1:0] rdata_ff;
   logic [LINES-1:0]  valid_ff;
   logic [IDX_W-1:0]  fill_ptr_ff [LINES];

   logic [CFG_LOG2_WIDTH-1:0] eff_log2;
   logic [CNT_W-1:0]          ways_calc;
   logic [IDX_W-1:0]          set_mask;
   logic [IDX_W-1:0]          set_calc;
   logic [IDX_W+CNT_W-1:0]    base_prod;
   logic [IDX_W-1:0]          cur_line;
   logic [CNT_W-1:0]          way_next;
   logic                      match;
   logic [IDX_W+CNT_W-1:0]    ptr_ext;
   logic [CNT_W-1:0]          ptr_cnt;
   logic [CNT_W-1:0]          ptr_use;
   logic [CNT_W-1:0]          ptr_inc;
   logic [CNT_W-1:0]          ptr_next;
   logic [IDX_W-1:0]          victim;
   logic [IDX_W-1:0]          place_line;
   logic                      place_we;
   logic                      ptr_we;
   logic [IDX_W+LINE_IDX_WIDTH-1:0] line_ext;

   // set geometry for the incoming address, set count capped at the largest power of two not above the line count
   always_comb begin
      eff_log2  = (set_log2 > MAX_LOG2) ? MAX_LOG2 : set_log2;
      ways_calc = CNT_W'(LINES) >> eff_log2;
      set_mask  = ~({IDX_W{1'b1}} << eff_log2);
      set_calc  = req.address[IDX_W-1:0] & set_mask;
      base_prod = {{CNT_W{1'b0}}, set_calc} * {{IDX_W{1'b0}}, ways_calc};
   end

   // way walk and fifo victim
   always_comb begin
      cur_line   = base_ff + way_ff[IDX_W-1:0];
      way_next   = way_ff + 1'b1;
      match      = valid_ff[cur_line] && (rdata_ff == addr_ff);
      ptr_ext    = {{CNT_W{1'b0}}, fill_ptr_ff[set_ff]};
      ptr_cnt    = ptr_ext[CNT_W-1:0];
      ptr_use    = (ptr_cnt >= ways_ff) ? '0 : ptr_cnt;
      ptr_inc    = ptr_use + 1'b1;
      ptr_next   = (ptr_inc >= ways_ff) ? '0 : ptr_inc;
      victim     = base_ff + ptr_use[IDX_W-1:0];
      place_line = free_found_ff ? free_line_ff : victim;
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      set_ff        <= set_in;
      base_ff       <= base_in;
      ways_ff       <= ways_in;
      way_ff        <= way_in;
      free_found_ff <= free_found_in;
      free_line_ff  <= free_line_in;
      hit_ff        <= hit_in;
      line_ff       <= line_in;
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      set_in        = set_ff;
      base_in       = base_ff;
      ways_in       = ways_ff;
      way_in        = way_ff;
      free_found_in = free_found_ff;
      free_line_in  = free_line_ff;
      hit_in        = hit_ff;
      line_in       = line_ff;
      place_we      = 1'b0;
      ptr_we        = 1'b0;
      req.ready     = 1'b0;
      rsp.valid     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               addr_in       = req.address[KEEP_W-1:0];
               set_in        = set_calc;
               base_in       = base_prod[IDX_W-1:0];
               ways_in       = ways_calc;
               way_in        = '0;
               free_found_in = 1'b0;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            // line read issued, data registered for the compare
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (match) begin
               hit_in   = 1'b1;
               line_in  = cur_line;
               state_in = ST_RESP;
            end else begin
               if (!valid_ff[cur_line] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_line_in  = cur_line;
               end
               way_in   = way_next;
               state_in = (way_next == ways_ff) ? ST_PLACE : ST_READ;
            end
         end
         ST_PLACE: begin
            // miss: lowest empty way, else the oldest fill of the set
            place_we = 1'b1;
            ptr_we   = !free_found_ff;
            hit_in   = 1'b0;
            line_in  = place_line;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // line address memory
   always_ff @(posedge clock) begin
      rdata_ff <= line_mem[cur_line];
      if (place_we) begin
         line_mem[place_line] <= addr_ff;
      end
   end

   // valid bits and fifo pointers, cleared on reset and on a set count write
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         fill_ptr_ff <= '{default: '0};
      end else begin
         if (place_we) begin
            valid_ff[place_line] <= 1'b1;
         end
         if (ptr_we) begin
            fill_ptr_ff[set_ff] <= ptr_next[IDX_W-1:0];
         end
      end
   end

   // response payload
   assign line_ext       = {{LINE_IDX_WIDTH{1'b0}}, line_ff};
   assign rsp.hit        = hit_ff;
   assign rsp.line_index = line_ext[LINE_IDX_WIDTH-1:0];

endmodule

`default_nettype wire

[design/set_associative_fifo_cache_lookup.sv]
`default_nettype none

// Set-associative address lookup with FIFO replacement over LINES lines. Each
// request transaction carries one address; the set is the address modulo the set
// count (2**set_count_log2, capped at the largest power of two not above LINES),
// and the lines of the set are compared one way at a time by a single comparator
// fed from the line memory, one read plus one compare per way. A hit ends the walk at
// the matching way; a miss walks every way of the set and then writes the line into
// the lowest empty way, else at the set's FIFO pointer, which it then steps. The
// sequencer returns to idle before the next request is taken; requests are not
// accepted while a lookup or its response is pending. The response gives hit and
// the line found or filled. Writing set_count_log2 (byte address 0) empties the
// cache; reset does the same and sets two sets.
module set_associative_fifo_cache_lookup import sacl_pkg::*; #(
   parameter int LINES      = 16,
   parameter int ADDR_WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   sacl_req_if.sink                       req,
   sacl_rsp_if.source                     rsp,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready
);

   logic [CFG_LOG2_WIDTH-1:0] set_log2;
   logic                      clear;

   // configuration registers
   sacl_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .set_log2 (set_log2),
      .clear    (clear)
   );

   // lookup sequencer with line store
   sacl_seq #(
      .LINES      (LINES),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .set_log2 (set_log2),
      .clear    (clear),
      .req      (req),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire
